>>> hdl/parking_gate_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Parking gate sequencer assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PARKING_GATE_SEQUENCER_MACROS_SVH
`define PARKING_GATE_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define PGS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pgs_pkg.sv
// ----------------------------------------------------------------------------
// pgs_pkg
// Types, codes and helpers shared by the parking gate sequencer.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int TIME_BITS_DEFAULT = 32;

    localparam int THR_W   = 10;
    localparam int DELAY_W = 8;
    localparam int DIST_W  = 11;
    localparam int NOW_W   = 32;
    localparam int PHASE_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CLOSE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_TIMEOUT     = 2'd2;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET  = 10'd10;
    localparam logic [DELAY_W-1:0] ENTRY_DLY_RESET  = 8'd5;
    localparam logic [DELAY_W-1:0] EXIT_TMO_RESET   = 8'd10;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    localparam logic [2:0] GS_IDLE       = 3'd0;
    localparam logic [2:0] GS_ENTRY_DET  = 3'd1;
    localparam logic [2:0] GS_ENTRY_WAIT = 3'd2;
    localparam logic [2:0] GS_EXIT_REQ   = 3'd3;
    localparam logic [2:0] GS_EXIT_VEH   = 3'd4;

    localparam logic [PHASE_W-1:0] BLINK_LAST_PHASE = 4'd9;
    localparam logic [PHASE_W-1:0] BLINK_ON_PHASES  = 4'd5;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'b00001,
        ST_ENTRY_DET  = 5'b00010,
        ST_ENTRY_WAIT = 5'b00100,
        ST_EXIT_REQ   = 5'b01000,
        ST_EXIT_VEH   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [THR_W-1:0]   detect_threshold_cm;
        logic [DELAY_W-1:0] entry_hold_sec;
        logic [DELAY_W-1:0] exit_limit_sec;
    } cfg_t;

    typedef struct packed {
        logic [2:0] gate_state;
        logic       blink_on;
        logic [1:0] gate_command;
    } result_t;

    function automatic logic [2:0] encode_state(mode_t m);
        logic [2:0] code;
        unique case (m)
            ST_ENTRY_DET:  code = GS_ENTRY_DET;
            ST_ENTRY_WAIT: code = GS_ENTRY_WAIT;
            ST_EXIT_REQ:   code = GS_EXIT_REQ;
            ST_EXIT_VEH:   code = GS_EXIT_VEH;
            default:       code = GS_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/pgs_step.sv
// ----------------------------------------------------------------------------
// pgs_step
// One poll tick of the gate rules: next state, time stamps, blink and result.
// ----------------------------------------------------------------------------
module pgs_step #(
    parameter int TIME_BITS = pgs_pkg::TIME_BITS_DEFAULT
) (
    input  pgs_pkg::mode_t                     mode,
    input  logic [TIME_BITS-1:0]               last_detect,
    input  logic [TIME_BITS-1:0]               exit_request,
    input  logic [pgs_pkg::PHASE_W-1:0]        phase,
    input  pgs_pkg::cfg_t                      cfg,
    input  logic                               switch_pressed,
    input  logic signed [pgs_pkg::DIST_W-1:0]  echo_cm,
    input  logic [TIME_BITS-1:0]               now,
    output pgs_pkg::mode_t                     mode_next,
    output logic [TIME_BITS-1:0]               last_detect_next,
    output logic [TIME_BITS-1:0]               exit_request_next,
    output logic [pgs_pkg::PHASE_W-1:0]        phase_next,
    output pgs_pkg::result_t                   result
);

    logic                 dist_pos;
    logic                 valid;
    logic                 in_range;
    logic                 present;
    logic                 far;
    logic                 open_exit;
    pgs_pkg::mode_t       mode_sw;
    logic [TIME_BITS-1:0] exit_stamp;
    logic                 entry_expired;
    logic                 exit_expired;
    logic [1:0]           cmd;

    assign dist_pos = !echo_cm[pgs_pkg::DIST_W-1];
    assign valid    = dist_pos && (|echo_cm[pgs_pkg::DIST_W-2:0]);
    assign in_range = echo_cm[pgs_pkg::DIST_W-2:0] <= cfg.detect_threshold_cm;
    assign present  = valid && in_range;
    assign far      = dist_pos && !in_range;

    // Exit switch is served before the rules, and only from idle.
    assign open_exit  = switch_pressed && (mode == pgs_pkg::ST_IDLE);
    assign mode_sw    = open_exit ? pgs_pkg::ST_EXIT_REQ : mode;
    assign exit_stamp = open_exit ? now : exit_request;

    assign entry_expired = (now - last_detect) >= TIME_BITS'(cfg.entry_hold_sec);
    assign exit_expired  = (now - exit_stamp) >= TIME_BITS'(cfg.exit_limit_sec);

    always_comb begin
        mode_next         = mode_sw;
        last_detect_next  = last_detect;
        exit_request_next = exit_stamp;
        cmd               = open_exit ? pgs_pkg::CMD_OPEN : pgs_pkg::CMD_NONE;
        unique case (mode_sw)
            pgs_pkg::ST_ENTRY_DET: begin
                if (present || far) begin
                    last_detect_next = now;
                end
                if (!present && far) begin
                    mode_next = pgs_pkg::ST_ENTRY_WAIT;
                end
            end
            pgs_pkg::ST_ENTRY_WAIT: begin
                if (entry_expired) begin
                    cmd       = pgs_pkg::CMD_CLOSE;
                    mode_next = pgs_pkg::ST_IDLE;
                end else if (present) begin
                    last_detect_next = now;
                    mode_next        = pgs_pkg::ST_ENTRY_DET;
                end
            end
            pgs_pkg::ST_EXIT_REQ: begin
                if (present) begin
                    mode_next        = pgs_pkg::ST_EXIT_VEH;
                    last_detect_next = now;
                end else if (exit_expired) begin
                    cmd       = pgs_pkg::CMD_CLOSE;
                    mode_next = pgs_pkg::ST_IDLE;
                end
            end
            pgs_pkg::ST_EXIT_VEH: begin
                // vehicle gone and timeout in one tick give a single close
                if (present) begin
                    last_detect_next = now;
                end
                if ((!present && far) || exit_expired) begin
                    cmd       = pgs_pkg::CMD_CLOSE;
                    mode_next = pgs_pkg::ST_IDLE;
                end
            end
            default: begin
                // idle
                if (present) begin
                    mode_next        = pgs_pkg::ST_ENTRY_DET;
                    cmd              = pgs_pkg::CMD_OPEN;
                    last_detect_next = now;
                end
            end
        endcase
    end

    always_comb begin
        if (mode_next != pgs_pkg::ST_IDLE) begin
            phase_next = (phase >= pgs_pkg::BLINK_LAST_PHASE) ? '0 : phase + 1'b1;
        end else begin
            phase_next = '0;
        end
    end

    assign result.gate_command = cmd;
    assign result.blink_on     = (mode_next != pgs_pkg::ST_IDLE)
                                 && (phase_next < pgs_pkg::BLINK_ON_PHASES);
    assign result.gate_state   = pgs_pkg::encode_state(mode_next);

endmodule

>>> hdl/parking_gate_sequencer.sv
// ----------------------------------------------------------------------------
// parking_gate_sequencer
// Entry/exit gate controller driven by 100 ms poll ticks.
// ----------------------------------------------------------------------------
// One transfer on the s_axis side is one poll tick; it yields exactly one
// result transfer on m_axis, in order. The path is two registers deep: the
// tick is captured in an input register, the gate rules run in combinational
// logic, and the result plus the updated gate state are written together
// when the tick moves into the result register, which then offers it on
// m_axis. With m_axis_tready held high the block takes one tick every cycle,
// and updating state and time stamps together with each result is what
// lets it keep that rate.
// Stalls on m_axis back up through both registers without loss. The three
// settings registers are written through the cfg port (always ready) and
// should only change while no tick is in flight; indexes past the last
// register are dropped.
`include "parking_gate_sequencer_macros.svh"

module parking_gate_sequencer #(
    parameter int TIME_BITS = pgs_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // settings write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pgs_pkg::CFG_DATA_W-1:0]    cfg_data,
    // poll tick in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] switch_pressed, [11:1] echo_cm, [43:12] now_sec, [47:44] zero
    input  logic [47:0]                       s_axis_tdata,
    // result out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] gate_command, [2] blink_on, [5:3] gate_state, [7:6] zero
    output logic [7:0]                        m_axis_tdata
);

    // now_sec is 32 bits; only the low TIME_BITS of it take part in timing
    localparam int NOW_KEEP = (TIME_BITS < pgs_pkg::NOW_W) ? TIME_BITS : pgs_pkg::NOW_W;

    // settings
    pgs_pkg::cfg_t cfg_reg;

    // input register
    logic                                in_valid_reg;
    logic                                in_switch_reg;
    logic signed [pgs_pkg::DIST_W-1:0]   in_dist_reg;
    logic [NOW_KEEP-1:0]                 in_now_reg;

    // gate state
    pgs_pkg::mode_t                      mode_reg;
    logic [TIME_BITS-1:0]                last_detect_reg;
    logic [TIME_BITS-1:0]                exit_request_reg;
    logic [pgs_pkg::PHASE_W-1:0]         phase_reg;

    // result register
    logic                                out_valid_reg;
    pgs_pkg::result_t                    out_result_reg;

    // step outputs
    pgs_pkg::mode_t                      mode_next;
    logic [TIME_BITS-1:0]                last_detect_next;
    logic [TIME_BITS-1:0]                exit_request_next;
    logic [pgs_pkg::PHASE_W-1:0]         phase_next;
    pgs_pkg::result_t                    result_next;

    logic                                out_free;
    logic                                advance;
    logic                                take_in;

    // Result stage is free when empty or being drained this cycle.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign take_in       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // ---------------- settings ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detect_threshold_cm <= pgs_pkg::THRESHOLD_RESET;
            cfg_reg.entry_hold_sec      <= pgs_pkg::ENTRY_DLY_RESET;
            cfg_reg.exit_limit_sec      <= pgs_pkg::EXIT_TMO_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pgs_pkg::CFG_DETECT_THRESHOLD:
                    cfg_reg.detect_threshold_cm <= cfg_data[pgs_pkg::THR_W-1:0];
                pgs_pkg::CFG_ENTRY_CLOSE_DELAY:
                    cfg_reg.entry_hold_sec <= cfg_data[pgs_pkg::DELAY_W-1:0];
                pgs_pkg::CFG_EXIT_TIMEOUT:
                    cfg_reg.exit_limit_sec <= cfg_data[pgs_pkg::DELAY_W-1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_switch_reg <= s_axis_tdata[0];
            in_dist_reg   <= s_axis_tdata[11:1];
            in_now_reg    <= s_axis_tdata[12 +: NOW_KEEP];
        end
    end

    // ---------------- rule logic ----------------
    pgs_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .mode              (mode_reg),
        .last_detect       (last_detect_reg),
        .exit_request      (exit_request_reg),
        .phase             (phase_reg),
        .cfg               (cfg_reg),
        .switch_pressed    (in_switch_reg),
        .echo_cm           (in_dist_reg),
        .now               (TIME_BITS'(in_now_reg)),
        .mode_next         (mode_next),
        .last_detect_next  (last_detect_next),
        .exit_request_next (exit_request_next),
        .phase_next        (phase_next),
        .result            (result_next)
    );

    // State commits only when the tick moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= pgs_pkg::ST_IDLE;
            last_detect_reg  <= '0;
            exit_request_reg <= '0;
            phase_reg        <= '0;
        end else if (advance) begin
            mode_reg         <= mode_next;
            last_detect_reg  <= last_detect_next;
            exit_request_reg <= exit_request_next;
            phase_reg        <= phase_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_result_reg.gate_state,
                            out_result_reg.blink_on, out_result_reg.gate_command};

    // ---------------- assertions ----------------
    `PGS_ASSERT_IMPL(a_idle_dark, m_axis_tvalid && (m_axis_tdata[5:3] == pgs_pkg::GS_IDLE), m_axis_tdata[2] == 1'b0, "blink on while idle")
    `PGS_ASSERT_IMPL(a_close_to_idle, m_axis_tvalid && (m_axis_tdata[1:0] == pgs_pkg::CMD_CLOSE), m_axis_tdata[5:3] == pgs_pkg::GS_IDLE, "close without return to idle")
    `PGS_ASSERT_IMPL(a_open_state, m_axis_tvalid && (m_axis_tdata[1:0] == pgs_pkg::CMD_OPEN), (m_axis_tdata[5:3] == pgs_pkg::GS_ENTRY_DET) || (m_axis_tdata[5:3] == pgs_pkg::GS_EXIT_REQ) || (m_axis_tdata[5:3] == pgs_pkg::GS_EXIT_VEH), "open in wrong state")
    `PGS_ASSERT_IMPL(a_phase_range, 1'b1, phase_reg <= pgs_pkg::BLINK_LAST_PHASE, "blink phase out of range")
    `PGS_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
    `PGS_ASSERT_NEXT(a_state_hold, !advance, $stable(mode_reg) && $stable(phase_reg), "state changed without a tick")

endmodule

>>> tb/sv/tb_parking_gate_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_parking_gate_sequencer
// Self-checking bench for the parking gate sequencer.
// ----------------------------------------------------------------------------
// Poll ticks go in on s_axis in random bursts. A scoreboard runs its own model
// of the gate rules and checks every m_axis result, field by field, in order.
// Runs of ticks follow a vehicle's presence and the seconds count. The bench
// covers a directed set of corner ticks and then random traffic under several
// register settings, including the largest values and zero values.
// ----------------------------------------------------------------------------
module tb_parking_gate_sequencer;
    import pgs_pkg::*;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int SETTLE_CYCLES = 6;      // two-stage path plus margin
    localparam int RANDOM_TICKS = 230;     // per settings phase
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {DK_PRESENT, DK_FAR, DK_NO_READING, DK_NOISE} dist_kind_e;

    // ------------------------------------------------------------------------
    // Gate model and expected-result queue
    // ------------------------------------------------------------------------
    class gate_scoreboard;
        logic [THR_W-1:0]   threshold;
        logic [DELAY_W-1:0] entry_delay;
        logic [DELAY_W-1:0] exit_timeout;
        logic [2:0]         gate_mode;
        logic [NOW_W-1:0]   last_seen_sec;
        logic [NOW_W-1:0]   exit_start_sec;
        logic [PHASE_W-1:0] blink_phase;
        result_t            expected_results[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        opens;
        int unsigned        closes;
        logic [4:0]         modes_seen;

        function new();
            threshold      = THRESHOLD_RESET;
            entry_delay    = ENTRY_DLY_RESET;
            exit_timeout   = EXIT_TMO_RESET;
            gate_mode      = GS_IDLE;
            last_seen_sec  = '0;
            exit_start_sec = '0;
            blink_phase    = '0;
            errors         = 0;
            checked        = 0;
            opens          = 0;
            closes         = 0;
            modes_seen     = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DETECT_THRESHOLD:  threshold    = data[THR_W-1:0];
                CFG_ENTRY_CLOSE_DELAY: entry_delay  = data[DELAY_W-1:0];
                CFG_EXIT_TIMEOUT:      exit_timeout = data[DELAY_W-1:0];
                default: ;             // unused index is dropped
            endcase
        endfunction

        // One accepted poll tick -> one expected result.
        function void note_tick(logic sw, logic signed [DIST_W-1:0] range_cm,
                                logic [NOW_W-1:0] now);
            int      d;
            bit      present;
            bit      far;
            result_t res;

            d       = int'(range_cm);
            present = (d > 0) && (d <= int'(threshold));
            far     = d > int'(threshold);
            res.gate_command = CMD_NONE;

            // switch press only counts in idle
            if (sw && gate_mode == GS_IDLE) begin
                res.gate_command = CMD_OPEN;
                exit_start_sec   = now;
                gate_mode        = GS_EXIT_REQ;
            end

            case (gate_mode)
                GS_ENTRY_DET: begin
                    if (present) begin
                        last_seen_sec = now;
                    end else if (far) begin
                        last_seen_sec = now;
                        gate_mode     = GS_ENTRY_WAIT;
                    end
                end
                GS_ENTRY_WAIT: begin
                    if (NOW_W'(now - last_seen_sec) >= NOW_W'(entry_delay)) begin
                        res.gate_command = CMD_CLOSE;
                        gate_mode        = GS_IDLE;
                    end else if (present) begin
                        last_seen_sec = now;
                        gate_mode     = GS_ENTRY_DET;
                    end
                end
                GS_EXIT_REQ: begin
                    if (present) begin
                        gate_mode     = GS_EXIT_VEH;
                        last_seen_sec = now;
                    end else if (NOW_W'(now - exit_start_sec) >= NOW_W'(exit_timeout)) begin
                        res.gate_command = CMD_CLOSE;
                        gate_mode        = GS_IDLE;
                    end
                end
                GS_EXIT_VEH: begin
                    if (present) begin
                        last_seen_sec = now;
                    end else if (far) begin
                        res.gate_command = CMD_CLOSE;
                        gate_mode        = GS_IDLE;
                    end
                    // vehicle leaving and timeout in the same tick give one close
                    if (NOW_W'(now - exit_start_sec) >= NOW_W'(exit_timeout)) begin
                        res.gate_command = CMD_CLOSE;
                        gate_mode        = GS_IDLE;
                    end
                end
                default: begin
                    if (present) begin
                        gate_mode        = GS_ENTRY_DET;
                        res.gate_command = CMD_OPEN;
                        last_seen_sec    = now;
                    end
                end
            endcase

            if (gate_mode != GS_IDLE) begin
                blink_phase  = (blink_phase == BLINK_LAST_PHASE) ? '0 : blink_phase + 1'b1;
                res.blink_on = blink_phase < BLINK_ON_PHASES;
            end else begin
                blink_phase  = '0;
                res.blink_on = 1'b0;
            end
            res.gate_state = gate_mode;

            if (res.gate_command == CMD_OPEN) opens++;
            if (res.gate_command == CMD_CLOSE) closes++;
            modes_seen[gate_mode] = 1'b1;
            expected_results.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30) $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [7:0] data);
            result_t got;
            result_t want;

            got = result_t'(data[5:0]);
            if (expected_results.size() == 0) begin
                report($sformatf("result 0x%02h arrived with nothing expected", data));
            end else begin
                want = expected_results.pop_front();
                checked++;
                if (got.gate_command !== want.gate_command)
                    report($sformatf("result %0d: gate_command %0d, expected %0d",
                                     checked, got.gate_command, want.gate_command));
                if (got.blink_on !== want.blink_on)
                    report($sformatf("result %0d: blink_on %0b, expected %0b",
                                     checked, got.blink_on, want.blink_on));
                if (got.gate_state !== want.gate_state)
                    report($sformatf("result %0d: gate_state %0d, expected %0d",
                                     checked, got.gate_state, want.gate_state));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input is driven to a known value from time zero
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [0] switch_pressed, [11:1] echo_cm, [43:12] now_sec, [47:44] zero
    logic [47:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] gate_command, [2] blink_on, [5:3] gate_state, [7:6] zero
    logic [7:0]            m_axis_tdata;

    parking_gate_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gate_scoreboard   sb = new();
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 1;
    int unsigned      settings_used = 1;   // reset settings count as the first
    logic [NOW_W-1:0] now_clock = '0;
    logic [THR_W-1:0] cur_threshold = THRESHOLD_RESET;
    dist_kind_e       dist_kind = DK_NO_READING;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check on handshake, stall on a pattern of its own
    // (always ready, coin flip per cycle, or a solid stall).
    // ------------------------------------------------------------------------
    int unsigned rx_left = 0;
    int unsigned rx_mode = 0;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = (rx_mode == 2) ? $urandom_range(1, 12) : $urandom_range(5, 60);
        end
        rx_left--;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Tick sender: holds tvalid through a burst, drops it only for a gap.
    // ------------------------------------------------------------------------
    task automatic send_tick(input logic sw, input logic signed [DIST_W-1:0] range_cm,
                             input logic [NOW_W-1:0] now);
        int unsigned gap;

        s_axis_tdata  <= {4'b0, now, range_cm, sw};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_tick(sw, range_cm, now);
        now_clock = now;
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Random tick: seconds mostly creep forward, now and then jump or wrap;
    // the distance follows a vehicle that comes and goes.
    task automatic random_tick();
        int unsigned                r;
        logic                       sw;
        logic signed [DIST_W-1:0]   range_cm;
        logic [NOW_W-1:0]           now;

        now = now_clock;
        r = $urandom_range(0, 99);
        if (r >= 99)      now = $urandom();
        else if (r >= 95) now = now + $urandom_range(21, 300);
        else if (r >= 85) now = now + $urandom_range(2, 20);
        else if (r >= 40) now = now + 1;

        if ($urandom_range(0, 99) < 15) dist_kind = dist_kind_e'($urandom_range(0, 3));
        case (dist_kind)
            DK_PRESENT:
                range_cm = (cur_threshold == 0) ? DIST_W'(1)
                                                : DIST_W'($urandom_range(1, cur_threshold));
            DK_FAR:
                range_cm = (cur_threshold == 10'h3FF) ? DIST_W'(1023)
                                                      : DIST_W'($urandom_range(cur_threshold + 1, 1023));
            DK_NO_READING:
                range_cm = DIST_W'(-int'($urandom_range(0, 1024)));
            default:
                range_cm = DIST_W'($urandom());
        endcase
        sw = $urandom_range(0, 99) < 6;
        send_tick(sw, range_cm, now);
    endtask

    // Wait until every expected result is back and the pipe is empty.
    task automatic drain();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; hold keeps cfg_valid high for a write that follows.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit hold);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (!hold) cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr,
                                  input logic [CFG_DATA_W-1:0] entry_dly,
                                  input logic [CFG_DATA_W-1:0] exit_tmo);
        drain();
        cfg_write(CFG_DETECT_THRESHOLD, thr, 1'b1);
        cfg_write(CFG_ENTRY_CLOSE_DELAY, entry_dly, 1'b1);
        cfg_write(CFG_EXIT_TIMEOUT, exit_tmo, 1'b0);
        cur_threshold = thr[THR_W-1:0];
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks under reset settings (threshold 10, delay 5, timeout 10).
        send_tick(1'b0, -11'sd1, 32'd100);      // no reading
        send_tick(1'b0, 11'sd0, 32'd100);       // zero is no reading
        send_tick(1'b0, -11'sd1024, 32'd100);   // most negative distance
        send_tick(1'b0, 11'sd1023, 32'd100);    // farthest, still idle
        send_tick(1'b0, 11'sd10, 32'd100);      // at threshold: entry opens
        send_tick(1'b0, 11'sd5, 32'd101);
        send_tick(1'b1, -11'sd1, 32'd102);      // switch outside idle ignored
        send_tick(1'b0, 11'sd11, 32'd103);      // just past threshold: waiting
        send_tick(1'b0, 11'sd1, 32'd104);       // back again
        send_tick(1'b0, 11'sd500, 32'd105);
        send_tick(1'b0, 11'sd0, 32'd109);       // one second short of delay
        send_tick(1'b0, 11'sd0, 32'd110);       // delay reached: close
        send_tick(1'b1, 11'sd3, 32'd200);       // exit open, car seen same tick
        send_tick(1'b0, 11'sd3, 32'd201);
        send_tick(1'b0, 11'sd20, 32'd202);      // exit car leaves: close
        send_tick(1'b1, -11'sd1, 32'd300);      // exit request, no car
        send_tick(1'b0, -11'sd1, 32'd309);
        send_tick(1'b0, 11'sd1023, 32'd310);    // exit timeout: close
        send_tick(1'b1, 11'sd0, 32'hFFFF_FFFE); // request just before wrap
        send_tick(1'b0, 11'sd2, 32'hFFFF_FFFF);
        send_tick(1'b0, 11'sd50, 32'd8);        // leave + timeout across wrap
        repeat (RANDOM_TICKS) random_tick();

        // Smallest nonzero settings.
        apply_settings(10'd1, 10'd1, 10'd1);
        repeat (RANDOM_TICKS) random_tick();

        // Largest settings; delay data above 8 bits is masked off.
        apply_settings(10'h3FF, 10'h3FF, 10'h1FF);
        repeat (RANDOM_TICKS) random_tick();

        // Zero settings, plus a write to the unused index that must be dropped.
        drain();
        cfg_write(CFG_UNUSED_INDEX, 10'h3FF, 1'b1);
        cfg_write(CFG_DETECT_THRESHOLD, 10'd0, 1'b1);
        cfg_write(CFG_ENTRY_CLOSE_DELAY, 10'd0, 1'b1);
        cfg_write(CFG_EXIT_TIMEOUT, 10'd0, 1'b0);
        cur_threshold = '0;
        settings_used++;
        send_tick(1'b1, 11'sd5, now_clock);     // open then close in one tick
        send_tick(1'b0, 11'sd1, now_clock);     // zero threshold: never present
        send_tick(1'b0, 11'sd1023, now_clock + 1);
        repeat (RANDOM_TICKS) random_tick();

        // Random mid-range settings, junk in the upper delay data bits.
        repeat (3) begin
            apply_settings(CFG_DATA_W'($urandom_range(1, 60)),
                           {2'($urandom()), 8'($urandom_range(1, 15))},
                           {2'($urandom()), 8'($urandom_range(1, 20))});
            repeat (RANDOM_TICKS) random_tick();
        end

        drain();
        $display("Checked %0d results over %0d register settings; %0d opens, %0d closes.",
                 sb.checked, settings_used, sb.opens, sb.closes);
        $display("Gate states reached (bit per state): %05b, mismatches: %0d",
                 sb.modes_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> parking_gate_sequencer.f
+incdir+hdl
hdl/pgs_pkg.sv
hdl/pgs_step.sv
hdl/parking_gate_sequencer.sv
tb/sv/tb_parking_gate_sequencer.sv
